// ===== src/cavd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cavd_pkg
// Shared types and constants for the comb-adaptive vertical deinterlacer.
// ----------------------------------------------------------------------------
package cavd_pkg;

    localparam int unsigned PIXEL_W = 8;
    localparam int unsigned THRESH_W = 16;
    localparam int unsigned TAPS = 7;

    localparam logic [PIXEL_W-1:0] MARK_VALUE = 8'd128;
    localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd12;

    // interpolation selector; code three behaves as cubic
    typedef enum logic [1:0] {
        INTERP_CUBIC     = 2'd0,
        INTERP_LINEAR    = 2'd1,
        INTERP_NEAREST   = 2'd2,
        INTERP_CUBIC_ALT = 2'd3
    } interp_mode_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_INTERP_MODE    = 2'd0,
        REG_FULL_FRAME     = 2'd1,
        REG_MARK_ONLY      = 2'd2,
        REG_COMB_THRESHOLD = 2'd3
    } reg_index_t;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // detection result of both windows
    typedef struct packed {
        logic upper;
        logic lower;
    } comb_flags_t;

endpackage

// ===== src/comb_adaptive_vertical_deinterlace.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comb_adaptive_vertical_deinterlace
// Per-pixel comb detection and vertical interpolation of luma.
// ----------------------------------------------------------------------------
// Each request carries the seven vertical luma neighbors (rows t-3..t+3) of
// one target pixel. Two four-row windows around the target are checked for
// interlace combing; a combed pixel (or every pixel in full-frame mode) is
// replaced by a cubic, linear or nearest interpolation from rows t-3, t-1,
// t+1, t+3 of the same field, or by 128 in mark mode. Otherwise the center
// sample passes through. comb_found reports detection in every mode.
// Throughput is one pixel per clock while the output is not stalled. A
// request passes one input register, then the detection and interpolation
// logic into the output register. An empty input register still takes a
// request while a result waits. Configuration is written through the cfg
// channel, always ready, and must only change while the pipeline is empty.
// ----------------------------------------------------------------------------
module comb_adaptive_vertical_deinterlace
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] row_minus3, [15:8] row_minus2, [23:16] row_minus1,
    // [31:24] row_centre, [39:32] row_plus1, [47:40] row_plus2,
    // [55:48] row_plus3
    input  logic [55:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_pixel
    output logic [7:0]  m_axis_tdata,
    // [0] comb_found
    output logic [0:0]  m_axis_tuser,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    cavd_pkg::interp_mode_t           interp_mode_reg;
    logic                             full_frame_reg;
    logic                             mark_only_reg;
    logic [cavd_pkg::THRESH_W-1:0]    comb_threshold_reg;
    logic                             cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_mode_reg    <= cavd_pkg::INTERP_CUBIC;
            full_frame_reg     <= 1'b0;
            mark_only_reg      <= 1'b0;
            comb_threshold_reg <= cavd_pkg::THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cavd_pkg::reg_index_t'(cfg_addr))
                cavd_pkg::REG_INTERP_MODE:
                    interp_mode_reg <= cavd_pkg::interp_mode_t'(cfg_data[1:0]);
                cavd_pkg::REG_FULL_FRAME:     full_frame_reg     <= cfg_data[0];
                cavd_pkg::REG_MARK_ONLY:      mark_only_reg      <= cfg_data[0];
                cavd_pkg::REG_COMB_THRESHOLD: comb_threshold_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: input register -> output register
    // ------------------------------------------------------------------
    logic                 in_valid_reg;
    logic                 out_valid_reg;
    logic                 out_advance;   // output register may load
    logic                 in_accept;
    cavd_pkg::pixel_t     tap_reg [cavd_pkg::TAPS];
    cavd_pkg::pixel_t     out_pixel_reg;
    logic                 comb_found_reg;

    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < cavd_pkg::TAPS; i++)
            begin
                tap_reg[i] <= s_axis_tdata[i*cavd_pkg::PIXEL_W +: cavd_pkg::PIXEL_W];
            end
        end
    end

    // ------------------------------------------------------------------
    // detection and interpolation
    // ------------------------------------------------------------------
    cavd_pkg::comb_flags_t flags;
    cavd_pkg::pixel_t      interp_pix;
    cavd_pkg::pixel_t      pixel_next;
    logic                  comb_next;

    // rows t-2..t+1
    cavd_comb_window u_win_upper
    (
        .s0        (tap_reg[1]),
        .s1        (tap_reg[2]),
        .s2        (tap_reg[3]),
        .s3        (tap_reg[4]),
        .threshold (comb_threshold_reg),
        .combs     (flags.upper)
    );

    // rows t-1..t+2
    cavd_comb_window u_win_lower
    (
        .s0        (tap_reg[2]),
        .s1        (tap_reg[3]),
        .s2        (tap_reg[4]),
        .s3        (tap_reg[5]),
        .threshold (comb_threshold_reg),
        .combs     (flags.lower)
    );

    cavd_interp u_interp
    (
        .v0    (tap_reg[0]),
        .v1    (tap_reg[2]),
        .v2    (tap_reg[4]),
        .v3    (tap_reg[6]),
        .mode  (interp_mode_reg),
        .pixel (interp_pix)
    );

    assign comb_next = flags.upper || flags.lower;

    always_comb
    begin
        priority if (!(comb_next || full_frame_reg))
        begin
            pixel_next = tap_reg[3];
        end
        else if (mark_only_reg)
        begin
            pixel_next = cavd_pkg::MARK_VALUE;
        end
        else
        begin
            pixel_next = interp_pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && in_valid_reg)
        begin
            out_pixel_reg  <= pixel_next;
            comb_found_reg <= comb_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_pixel_reg;
    assign m_axis_tuser[0] = comb_found_reg;

`ifndef NO_ASSERTIONS
    // input side only stalls when both stages hold data
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with an empty stage");

    // a bubble in the input stage reaches the output
    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (out_advance && !in_valid_reg) |=> !out_valid_reg)
        else $error("output valid without a source request");

    // full frame with mark mode always yields the marker
    a_mark_all: assert property (@(posedge clk) disable iff (!rst_n)
        (out_advance && in_valid_reg && full_frame_reg && mark_only_reg)
        |=> (m_axis_tdata == cavd_pkg::MARK_VALUE))
        else $error("marker not produced in full-frame mark mode");

    // undetected pixel in field mode passes the center sample
    a_pass_center: assert property (@(posedge clk) disable iff (!rst_n)
        (out_advance && in_valid_reg && !full_frame_reg && !comb_next)
        |=> (m_axis_tdata == $past(tap_reg[3]) && !m_axis_tuser[0]))
        else $error("center sample not passed through");
`endif

endmodule

// ===== src/cavd_comb_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cavd_comb_window
// Comb test on one four-sample vertical window.
// ----------------------------------------------------------------------------
module cavd_comb_window
(
    input  cavd_pkg::pixel_t                   s0,
    input  cavd_pkg::pixel_t                   s1,
    input  cavd_pkg::pixel_t                   s2,
    input  cavd_pkg::pixel_t                   s3,
    input  logic [cavd_pkg::THRESH_W-1:0]      threshold,
    output logic                               combs
);

    logic signed [8:0]  d02;
    logic signed [8:0]  d31;
    logic signed [9:0]  dc;
    logic signed [7:0]  br;
    logic signed [7:0]  bi;
    logic signed [8:0]  cr;
    logic [15:0]        br_sq;
    logic [15:0]        bi_sq;
    logic [15:0]        b_pow;
    logic [15:0]        c_pow;
    logic               peak;
    logic               dip;

    assign d02 = {1'b0, s0} - {1'b0, s2};
    assign d31 = {1'b0, s3} - {1'b0, s1};
    assign dc  = {2'b0, s0} - {2'b0, s1} + {2'b0, s2} - {2'b0, s3};

    // arithmetic shift right by one
    assign br = d02[8:1];
    assign bi = d31[8:1];
    assign cr = dc[9:1];

    assign br_sq = 16'(br * br);
    assign bi_sq = 16'(bi * bi);
    assign c_pow = 16'(cr * cr);
    assign b_pow = br_sq + bi_sq;   // at most 32768

    assign peak = (s0 < s1) && (s2 < s1) && (s2 < s3);
    assign dip  = (s0 > s1) && (s2 > s1) && (s2 > s3);

    assign combs = (c_pow > b_pow) && (c_pow > threshold) && (peak || dip);

endmodule

// ===== src/cavd_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cavd_interp
// Cubic, linear or nearest vertical interpolation from same-field rows.
// ----------------------------------------------------------------------------
module cavd_interp
(
    input  cavd_pkg::pixel_t       v0,
    input  cavd_pkg::pixel_t       v1,
    input  cavd_pkg::pixel_t       v2,
    input  cavd_pkg::pixel_t       v3,
    input  cavd_pkg::interp_mode_t mode,
    output cavd_pkg::pixel_t       pixel
);

    logic signed [9:0]  p;
    logic signed [10:0] q;
    logic signed [8:0]  r;
    logic signed [11:0] tot;
    logic signed [8:0]  d21;
    cavd_pkg::pixel_t   cubic_pix;
    cavd_pkg::pixel_t   linear_pix;

    assign p = {2'b0, v3} - {2'b0, v2} - {2'b0, v0} + {2'b0, v1};
    assign q = {3'b0, v0} - {3'b0, v1} - 11'(p);
    assign r = {1'b0, v2} - {1'b0, v0};

    assign tot = 12'(p >>> 3) + 12'(q >>> 2) + 12'(r >>> 1) + {4'b0, v1};

    // clamp to pixel range
    always_comb
    begin
        priority if (tot[11])
        begin
            cubic_pix = '0;
        end
        else if (|tot[10:8])
        begin
            cubic_pix = cavd_pkg::PIXEL_MAX;
        end
        else
        begin
            cubic_pix = tot[7:0];
        end
    end

    assign d21        = {1'b0, v2} - {1'b0, v1};
    assign linear_pix = 8'(10'(d21 >>> 1) + {2'b0, v1});

    always_comb
    begin
        unique case (mode)
            cavd_pkg::INTERP_LINEAR:    pixel = linear_pix;
            cavd_pkg::INTERP_NEAREST:   pixel = v1;
            cavd_pkg::INTERP_CUBIC,
            cavd_pkg::INTERP_CUBIC_ALT: pixel = cubic_pix;
            default:                    pixel = cubic_pix;
        endcase
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the comb-adaptive vertical deinterlacer.
// ----------------------------------------------------------------------------
// Columns of seven luma rows are streamed into the block. A behavioral
// predictor works out the expected pixel and comb flag for each accepted
// request, and every result is checked against it in order. A directed part
// covers the register reset values, every interpolation selector, mark mode,
// full-frame mode, the cubic clamps and the threshold extremes. Random phases
// then follow with new register settings, half comb-shaped columns, and
// random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PIPE_LATENCY = 2;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int MAX_IDLE = 11;

    // [0] = row t-3
    typedef logic [cavd_pkg::TAPS-1:0][cavd_pkg::PIXEL_W-1:0] column_t;

    typedef struct {
        cavd_pkg::pixel_t pixel;
        logic             comb;
    } deint_result_t;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;

    // shadow copy of the register file, as the block should hold it
    cavd_pkg::interp_mode_t        cur_interp = cavd_pkg::INTERP_CUBIC;
    logic                          cur_full_frame = 1'b0;
    logic                          cur_mark_only = 1'b0;
    logic [cavd_pkg::THRESH_W-1:0] cur_threshold = cavd_pkg::THRESHOLD_RESET;

    // pixels predicted for accepted requests, oldest first
    deint_result_t expected_pixels[$];

    // idle control for each stream side
    logic send_idle_on = 1'b1;
    logic recv_idle_on = 1'b1;

    int error_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int combs_seen = 0;
    int reg_writes = 0;
    int settings_used = 1;

    comb_adaptive_vertical_deinterlace dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic cavd_pkg::pixel_t clip_pixel(input int v);
        if (v < 0)
            return '0;
        if (v > int'(cavd_pkg::PIXEL_MAX))
            return cavd_pkg::PIXEL_MAX;
        return cavd_pkg::pixel_t'(v);
    endfunction

    // one four-row window: strong alternating power plus a strict zigzag
    function automatic logic window_combs(input int s0, input int s1,
                                          input int s2, input int s3);
        int br;
        int bi;
        int cr;
        int pow_b;
        int pow_c;
        logic peak;
        logic dip;
        br = (s0 - s2) >>> 1;
        bi = (s3 - s1) >>> 1;
        cr = (s0 - s1 + s2 - s3) >>> 1;
        pow_b = br * br + bi * bi;
        pow_c = cr * cr;
        peak = (s0 < s1) && (s2 < s1) && (s2 < s3);
        dip = (s0 > s1) && (s2 > s1) && (s2 > s3);
        return (pow_c > pow_b) && (pow_c > int'(cur_threshold)) && (peak || dip);
    endfunction

    // v0..v3 are rows t-3, t-1, t+1, t+3 of the same field
    function automatic cavd_pkg::pixel_t interpolate_field(input int v0, input int v1,
                                                           input int v2, input int v3);
        int p;
        int q;
        int r;
        case (cur_interp)
            cavd_pkg::INTERP_LINEAR:  return cavd_pkg::pixel_t'(((v2 - v1) >>> 1) + v1);
            cavd_pkg::INTERP_NEAREST: return cavd_pkg::pixel_t'(v1);
            default:
            begin
                p = (v3 - v2) - (v0 - v1);
                q = (v0 - v1) - p;
                r = v2 - v0;
                return clip_pixel((p >>> 3) + (q >>> 2) + (r >>> 1) + v1);
            end
        endcase
    endfunction

    function automatic deint_result_t predict_pixel(input column_t col);
        deint_result_t res;
        int s [cavd_pkg::TAPS];
        int i;
        for (i = 0; i < cavd_pkg::TAPS; i++)
            s[i] = int'(col[i]);
        res.comb = window_combs(s[1], s[2], s[3], s[4]) ||
                   window_combs(s[2], s[3], s[4], s[5]);
        if (res.comb || cur_full_frame)
            res.pixel = cur_mark_only ? cavd_pkg::MARK_VALUE
                                      : interpolate_field(s[0], s[2], s[4], s[6]);
        else
            res.pixel = col[3];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic column_t rows_to_column(input cavd_pkg::pixel_t m3,
                                               input cavd_pkg::pixel_t m2,
                                               input cavd_pkg::pixel_t m1,
                                               input cavd_pkg::pixel_t c,
                                               input cavd_pkg::pixel_t p1,
                                               input cavd_pkg::pixel_t p2,
                                               input cavd_pkg::pixel_t p3);
        return {p3, p2, p1, c, m1, m2, m3};
    endfunction

    // half zigzag columns so that the detector fires often, the rest
    // ramps, noise and saturated rows
    function automatic column_t make_column();
        column_t col;
        int pick;
        int base;
        int amp;
        int step;
        int jitter;
        int phase;
        int val;
        int i;
        pick = $urandom_range(0, 99);
        base = $urandom_range(0, 255);
        amp = $urandom_range(0, 127);
        step = int'($urandom_range(0, 80)) - 40;
        phase = $urandom_range(0, 1);
        for (i = 0; i < cavd_pkg::TAPS; i++)
        begin
            jitter = int'($urandom_range(0, 6)) - 3;
            if (pick < 50)
                val = base + ((((i + phase) % 2) == 0) ? amp : -amp) + jitter;
            else if (pick < 65)
                val = base + step * (i - 3);
            else if (pick < 90)
                val = $urandom_range(0, 255);
            else
                val = ($urandom_range(0, 1) != 0) ? 255 : 0;
            col[i] = clip_pixel(val);
        end
        return col;
    endfunction

    function automatic int draw_idle(input logic idle_on);
        return idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Request side: one column per call. valid is left high after an
    // accept so that back-to-back requests never drop it.
    // ------------------------------------------------------------------
    task automatic send_column(input column_t col);
        int gap;
        gap = draw_idle(send_idle_on);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= col;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_pixels.push_back(predict_pixel(col));
        requests_sent++;
    endtask

    // drop valid and let every pending result come out
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // registers change only with the pipeline empty
    task automatic write_reg(input cavd_pkg::reg_index_t idx, input logic [15:0] value);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            cavd_pkg::REG_INTERP_MODE:    cur_interp = cavd_pkg::interp_mode_t'(value[1:0]);
            cavd_pkg::REG_FULL_FRAME:     cur_full_frame = value[0];
            cavd_pkg::REG_MARK_ONLY:      cur_mark_only = value[0];
            cavd_pkg::REG_COMB_THRESHOLD: cur_threshold = value;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: ready drops for a random stall before each result
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = draw_idle(recv_idle_on);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // every result is compared with the oldest prediction
    always @(posedge clk)
    begin : result_compare
        deint_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("unexpected result pixel=%0d comb=%0b",
                                          m_axis_tdata, m_axis_tuser[0]));
            else
            begin
                want = expected_pixels.pop_front();
                results_checked++;
                if (want.comb)
                    combs_seen++;
                if (m_axis_tdata !== want.pixel)
                    report_mismatch($sformatf("out_pixel got %0d want %0d",
                                              m_axis_tdata, want.pixel));
                if (m_axis_tuser[0] !== want.comb)
                    report_mismatch($sformatf("comb_found got %0b want %0b",
                                              m_axis_tuser[0], want.comb));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset values: cubic, detection on, threshold 12
    task automatic test_register_reset();
        send_column(rows_to_column(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_column(rows_to_column(8'd255, 8'd255, 8'd255, 8'd255,
                                   8'd255, 8'd255, 8'd255));
        // comb power 16 sits just over the reset threshold
        send_column(rows_to_column(8'd12, 8'd10, 8'd14, 8'd10, 8'd14, 8'd10, 8'd12));
        // comb power 9 stays under it
        send_column(rows_to_column(8'd12, 8'd10, 8'd13, 8'd10, 8'd13, 8'd10, 8'd12));
        // full-swing zigzag, both windows comb
        send_column(rows_to_column(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255));
        send_column(rows_to_column(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0));
    endtask

    // full frame forces interpolation; comb_found still reports detection
    task automatic test_interp_modes();
        int m;
        write_reg(cavd_pkg::REG_FULL_FRAME, 16'h0001);
        for (m = 0; m < 4; m++)
        begin
            // upper bits of the selector word must be ignored
            write_reg(cavd_pkg::REG_INTERP_MODE, {14'h2A5B, 2'(m)});
            settings_used++;
            // cubic overshoots high and low here
            send_column(rows_to_column(8'd0, 8'd7, 8'd255, 8'd9, 8'd255, 8'd3, 8'd0));
            send_column(rows_to_column(8'd255, 8'd40, 8'd0, 8'd200, 8'd0, 8'd40, 8'd255));
        end
    endtask

    task automatic test_mark_modes();
        write_reg(cavd_pkg::REG_INTERP_MODE, {14'h0000, cavd_pkg::INTERP_CUBIC});
        write_reg(cavd_pkg::REG_FULL_FRAME, 16'hFFFE);      // bit 0 clear: detection on
        write_reg(cavd_pkg::REG_MARK_ONLY, 16'h8001);
        settings_used++;
        send_column(rows_to_column(8'd90, 8'd20, 8'd200, 8'd20, 8'd200, 8'd20, 8'd90));
        send_column(rows_to_column(8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70));
        // full frame together with mark: every pixel becomes the marker
        write_reg(cavd_pkg::REG_FULL_FRAME, 16'h0001);
        settings_used++;
        send_column(rows_to_column(8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70));
        send_column(rows_to_column(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0));
    endtask

    task automatic test_threshold_extremes();
        write_reg(cavd_pkg::REG_FULL_FRAME, 16'h0000);
        write_reg(cavd_pkg::REG_MARK_ONLY, 16'h0000);
        write_reg(cavd_pkg::REG_COMB_THRESHOLD, 16'h0000);
        settings_used++;
        // comb power 1 is enough with a zero threshold
        send_column(rows_to_column(8'd10, 8'd10, 8'd11, 8'd10, 8'd11, 8'd10, 8'd10));
        send_column(rows_to_column(8'd50, 8'd50, 8'd50, 8'd50, 8'd50, 8'd50, 8'd50));
        // no column can reach the largest threshold
        write_reg(cavd_pkg::REG_COMB_THRESHOLD, 16'hFFFF);
        settings_used++;
        send_column(rows_to_column(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255));
    endtask

    // random register settings, random columns, random idling per phase
    task automatic test_random_phases();
        int phase;
        logic [15:0] noise;
        logic [15:0] thresh;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            noise = 16'($urandom);
            if (phase == 0)
                thresh = 16'h0000;
            else if (phase == 1)
                thresh = 16'hFFFF;
            else if ($urandom_range(0, 2) == 0)
                thresh = 16'($urandom_range(0, 65535));
            else
                thresh = 16'($urandom_range(0, 400));
            write_reg(cavd_pkg::REG_INTERP_MODE, {noise[15:2], 2'(phase % 4)});
            write_reg(cavd_pkg::REG_FULL_FRAME, {noise[15:1], ($urandom_range(0, 3) == 0)});
            write_reg(cavd_pkg::REG_MARK_ONLY, {noise[14:0], ($urandom_range(0, 3) == 0)});
            write_reg(cavd_pkg::REG_COMB_THRESHOLD, thresh);
            settings_used++;
            // one phase runs with no idle cycles on either side
            if (phase == 2)
            begin
                send_idle_on = 1'b0;
                recv_idle_on = 1'b0;
            end
            else
            begin
                send_idle_on = ($urandom_range(0, 3) != 0);
                recv_idle_on = ($urandom_range(0, 3) != 0);
            end
            repeat (PHASE_ITEMS) send_column(make_column());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_interp_modes();
        test_mark_modes();
        test_threshold_extremes();
        test_random_phases();

        drain_pipeline();
        $display("run covered %0d requests under %0d register settings (%0d writes)",
                 requests_sent, settings_used, reg_writes);
        $display("%0d results compared, %0d flagged as combed, %0d mismatches",
                 results_checked, combs_seen, error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
src/cavd_pkg.sv
src/cavd_comb_window.sv
src/cavd_interp.sv
src/comb_adaptive_vertical_deinterlace.sv
bench/testbench.sv
